>>> design/commit_rollback_ring_queue_top_assert.svh
// Assertion macros for the commit/rollback ring queue.
// Included by commit_rollback_ring_queue_top; no other dependencies.
`ifndef COMMIT_ROLLBACK_RING_QUEUE_TOP_ASSERT_SVH
`define COMMIT_ROLLBACK_RING_QUEUE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CRRQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crrq assertion failed");
`define CRRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crrq assertion failed");
`else
`define CRRQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CRRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/crrq_pkg.sv
// Shared types and constants for the commit/rollback ring queue.
// No dependencies.
package crrq_pkg;

	localparam int RING_DEPTH_DEF  = 256;
	localparam int ENTRY_WIDTH_DEF = 32;
	localparam int OP_W            = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_BEGIN  = 2'd2,
		OP_COMMIT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

endpackage

>>> design/crrq_ctrl.sv
// Controller FSM for the commit/rollback ring queue: request handshakes.
// Depends on crrq_pkg.
module crrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output crrq_pkg::ctrl_cmd_t cmd
);

	crrq_pkg::state_t state_q;
	crrq_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			crrq_pkg::ST_IDLE: begin
				if (in_valid) state_d = crrq_pkg::ST_EXEC;
			end
			crrq_pkg::ST_EXEC: begin
				state_d = crrq_pkg::ST_OUT;
			end
			crrq_pkg::ST_OUT: begin
				if (!out_stall) state_d = crrq_pkg::ST_IDLE;
			end
			default: begin
				state_d = crrq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crrq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall    = (state_q != crrq_pkg::ST_IDLE);
	assign out_valid   = (state_q == crrq_pkg::ST_OUT);
	assign cmd.capture = in_valid && (state_q == crrq_pkg::ST_IDLE);
	assign cmd.execute = (state_q == crrq_pkg::ST_EXEC);

endmodule

>>> design/crrq_dp.sv
// Datapath for the commit/rollback ring queue: ring memory and pointers.
// Depends on crrq_pkg.
module crrq_dp #(
	parameter int RING_DEPTH  = crrq_pkg::RING_DEPTH_DEF,
	parameter int ENTRY_WIDTH = crrq_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  crrq_pkg::ctrl_cmd_t       cmd,
	input  logic [crrq_pkg::OP_W-1:0] op,
	input  logic [ENTRY_WIDTH-1:0]    entry_in,
	output logic [ENTRY_WIDTH-1:0]    entry_out,
	output logic                      found,
	output logic                      overflow
);

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

	logic [ENTRY_WIDTH-1:0] mem [RING_DEPTH];

	crrq_pkg::op_t          op_q;
	logic [ENTRY_WIDTH-1:0] entry_q;
	logic [ENTRY_WIDTH-1:0] rd_data_q;
	logic                   found_q;
	logic                   overflow_q;

	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] cm_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_next;
	logic [PTR_W-1:0] wr_next;

	logic is_push;
	logic is_pop;
	logic ring_full;
	logic ring_empty;
	logic mem_we;
	logic mem_re;

	assign rd_next    = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
	assign wr_next    = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
	assign ring_full  = (wr_next == rd_ptr_q);
	assign ring_empty = (rd_ptr_q == cm_ptr_q);
	assign is_push    = (op_q == crrq_pkg::OP_PUSH);
	assign is_pop     = (op_q == crrq_pkg::OP_POP);
	assign mem_we     = cmd.execute && is_push && !ring_full;
	assign mem_re     = cmd.execute && is_pop && !ring_empty;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= crrq_pkg::op_t'(op);
			entry_q <= entry_in;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_ptr_q] <= entry_q;
		if (mem_re) rd_data_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			found_q    <= is_pop && !ring_empty;
			overflow_q <= is_push && ring_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			cm_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else if (cmd.execute) begin
			case (op_q)
				crrq_pkg::OP_PUSH: begin
					if (!ring_full) wr_ptr_q <= wr_next;
				end
				crrq_pkg::OP_POP: begin
					if (!ring_empty) rd_ptr_q <= rd_next;
				end
				crrq_pkg::OP_BEGIN: begin
					wr_ptr_q <= cm_ptr_q;
				end
				crrq_pkg::OP_COMMIT: begin
					cm_ptr_q <= wr_ptr_q;
				end
				default: begin
					cm_ptr_q <= cm_ptr_q;
				end
			endcase
		end
	end

	assign entry_out = found_q ? rd_data_q : '0;
	assign found     = found_q;
	assign overflow  = overflow_q;

endmodule

>>> design/commit_rollback_ring_queue_top.sv
// Commit/rollback ring queue of entry handles. A push stores a tentative
// entry, a commit publishes all tentative entries, a begin drops the ones
// not yet committed, and a pop returns the oldest committed entry (found=0
// and entry_out=0 if none). A push into a full ring (RING_DEPTH-1 entries)
// is dropped with overflow=1. Each request yields one result and passes
// through capture, one ring memory access with pointer update, and the
// result register, which holds while out_stall is high; the next request
// is accepted once the result is taken. No clearing pass is needed after
// reset. Depends on crrq_pkg, crrq_ctrl, crrq_dp and the assertion
// header.
`include "commit_rollback_ring_queue_top_assert.svh"

module commit_rollback_ring_queue_top #(
	parameter int RING_DEPTH  = crrq_pkg::RING_DEPTH_DEF,
	parameter int ENTRY_WIDTH = crrq_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [crrq_pkg::OP_W-1:0] op,
	input  logic [ENTRY_WIDTH-1:0]    entry_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ENTRY_WIDTH-1:0]    entry_out,
	output logic                      found,
	output logic                      overflow
);

	crrq_pkg::ctrl_cmd_t cmd;

	crrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	crrq_dp #(
		.RING_DEPTH (RING_DEPTH),
		.ENTRY_WIDTH(ENTRY_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.op       (op),
		.entry_in (entry_in),
		.entry_out(entry_out),
		.found    (found),
		.overflow (overflow)
	);

	`CRRQ_ASSERT_NEXT(a_accept_then_exec, clk, arst_n, in_valid && !in_stall, cmd.execute && !out_valid)
	`CRRQ_ASSERT_NEXT(a_exec_then_result, clk, arst_n, cmd.execute, out_valid)
	`CRRQ_ASSERT_SAME(a_one_in_flight, clk, arst_n, out_valid, in_stall)
	`CRRQ_ASSERT_SAME(a_miss_is_zero, clk, arst_n, out_valid && !found, entry_out == '0)

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for commit_rollback_ring_queue_top: directed table, then random
// transactions checked against an in-bench ring queue predictor with random idle and stall.
// Depends on crrq_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
	import crrq_pkg::*;

	localparam int DEPTH = RING_DEPTH_DEF;
	localparam int EW    = ENTRY_WIDTH_DEF;
	localparam int N_RANDOM = 1800;

	typedef logic [$clog2(DEPTH)-1:0] ring_ptr_t;

	typedef struct packed {
		logic [EW-1:0] entry;
		logic          found;
		logic          overflow;
	} queue_reply_t;

	typedef struct packed {
		op_t           op;
		logic [EW-1:0] entry;
		logic          typed;
		queue_reply_t  reply;
	} directed_row_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [OP_W-1:0] op;
	logic [EW-1:0] entry_in;
	logic          out_valid;
	logic          out_stall;
	logic [EW-1:0] entry_out;
	logic          found;
	logic          overflow;

	commit_rollback_ring_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.entry_in  (entry_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.entry_out (entry_out),
		.found     (found),
		.overflow  (overflow)
	);

	// predictor state
	logic [EW-1:0] ring_copy [DEPTH];
	ring_ptr_t     rd_ptr;
	ring_ptr_t     cm_ptr;
	ring_ptr_t     wr_ptr;

	queue_reply_t  awaited_replies [$];
	int            errors;
	int            sent;
	int            send_idle_pct;
	int            stall_pct;
	int            n_hits;
	int            n_empty_pops;
	int            n_dropped;
	int            n_rollbacks;

	directed_row_t directed_rows [0:24] = '{
		'{OP_POP,    32'hdeadbeef, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_COMMIT, 32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_BEGIN,  32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_PUSH,   32'h00000000, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_POP,    32'hffffffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_COMMIT, 32'h12345678, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_POP,    32'h0,        1'b1, '{32'h0, 1'b1, 1'b0}},
		'{OP_PUSH,   32'hffffffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_PUSH,   32'haaaaaaaa, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_BEGIN,  32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_POP,    32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_PUSH,   32'h55555555, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_PUSH,   32'hffffffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_COMMIT, 32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_COMMIT, 32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_POP,    32'h0,        1'b1, '{32'h55555555, 1'b1, 1'b0}},
		'{OP_POP,    32'h0,        1'b1, '{32'hffffffff, 1'b1, 1'b0}},
		'{OP_POP,    32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_BEGIN,  32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_BEGIN,  32'h0,        1'b1, '{32'h0, 1'b0, 1'b0}},
		'{OP_PUSH,   32'h80000000, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{OP_PUSH,   32'h00000001, 1'b0, '{32'h0, 1'b0, 1'b0}},
		'{OP_COMMIT, 32'h0,        1'b0, '{32'h0, 1'b0, 1'b0}},
		'{OP_POP,    32'h0,        1'b0, '{32'h0, 1'b0, 1'b0}},
		'{OP_POP,    32'h0,        1'b0, '{32'h0, 1'b0, 1'b0}}
	};

	function automatic ring_ptr_t ring_next(input ring_ptr_t p);
		return (p == ring_ptr_t'(DEPTH - 1)) ? ring_ptr_t'(0) : ring_ptr_t'(p + 1'b1);
	endfunction

	function automatic queue_reply_t ring_predict(input op_t req_op, input logic [EW-1:0] e);
		queue_reply_t r;
		r = '0;
		case (req_op)
			OP_PUSH: begin
				if (ring_next(wr_ptr) == rd_ptr) begin
					r.overflow = 1'b1;
				end else begin
					ring_copy[wr_ptr] = e;
					wr_ptr = ring_next(wr_ptr);
				end
			end
			OP_POP: begin
				if (rd_ptr != cm_ptr) begin
					r.entry = ring_copy[rd_ptr];
					r.found = 1'b1;
					rd_ptr = ring_next(rd_ptr);
				end
			end
			OP_BEGIN: begin
				if (wr_ptr != cm_ptr)
					n_rollbacks++;
				wr_ptr = cm_ptr;
			end
			default: begin
				cm_ptr = wr_ptr;
			end
		endcase
		return r;
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input op_t req_op, input logic [EW-1:0] req_entry,
			input logic typed = 1'b0, input queue_reply_t typed_reply = '0);
		queue_reply_t predicted;
		int phase;
		phase = (sent / 120) % 4;
		send_idle_pct = (phase == 1) ? 47 : (phase == 3) ? 27 : 0;
		stall_pct     = (phase == 2) ? 47 : (phase == 3) ? 27 : 0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op       = req_op;
		entry_in = req_entry;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = ring_predict(req_op, req_entry);
		awaited_replies.push_back(typed ? typed_reply : predicted);
		sent++;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		queue_reply_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_replies.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending: entry_out %h found %b overflow %b",
					$time, entry_out, found, overflow);
			end else begin
				exp_r = awaited_replies.pop_front();
				if (exp_r.found)
					n_hits++;
				if (exp_r.overflow)
					n_dropped++;
				if (entry_out !== exp_r.entry) begin
					errors++;
					$display("%0t: entry_out mismatch exp %h got %h",
						$time, exp_r.entry, entry_out);
				end
				if (found !== exp_r.found) begin
					errors++;
					$display("%0t: found mismatch exp %b got %b", $time, exp_r.found, found);
				end
				if (overflow !== exp_r.overflow) begin
					errors++;
					$display("%0t: overflow mismatch exp %b got %b",
						$time, exp_r.overflow, overflow);
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int kind;
		int n;
		int wait_cycles;
		bit fill_due;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_PUSH;
		entry_in      = '0;
		out_stall     = 1'b0;
		errors        = 0;
		sent          = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		n_hits        = 0;
		n_empty_pops  = 0;
		n_dropped     = 0;
		n_rollbacks   = 0;
		rd_ptr        = '0;
		cm_ptr        = '0;
		wr_ptr        = '0;
		fill_due      = 1'b1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].entry,
				directed_rows[i].typed, directed_rows[i].reply);

		while (sent < N_RANDOM + 25) begin
			kind = $urandom_range(99);
			if (sent > 900 && sent < 920)
				fill_due = 1'b1;
			if (fill_due || kind < 5) begin
				// push until the ring is full, then hit it again
				fill_due = 1'b0;
				while (ring_next(wr_ptr) != rd_ptr)
					send_request(OP_PUSH, $urandom);
				repeat ($urandom_range(1, 3))
					send_request(OP_PUSH, $urandom);
				send_request($urandom_range(1) ? OP_COMMIT : OP_BEGIN, $urandom);
			end else if (kind < 15) begin
				while (rd_ptr != cm_ptr)
					send_request(OP_POP, $urandom);
				repeat ($urandom_range(1, 2)) begin
					send_request(OP_POP, $urandom);
					n_empty_pops++;
				end
			end else if (kind < 88) begin
				n = $urandom_range(1, 8);
				if ($urandom_range(1))
					send_request(OP_BEGIN, $urandom);
				repeat (n) begin
					if ($urandom_range(99) < 30)
						send_request(OP_POP, $urandom);
					send_request(OP_PUSH, $urandom);
				end
				send_request(($urandom_range(99) < 80) ? OP_COMMIT : OP_BEGIN, $urandom);
				repeat ($urandom_range(0, 3))
					send_request(OP_POP, $urandom);
			end else begin
				repeat ($urandom_range(1, 6))
					send_request(op_t'($urandom_range(3)), $urandom);
			end
		end
		in_valid = 1'b0;

		wait_cycles = 0;
		while (awaited_replies.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (awaited_replies.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, awaited_replies.size());
		end

		$display("tb: %0d requests sent; %0d pops returned data, %0d pushes dropped on full ring",
			sent, n_hits, n_dropped);
		$display("tb: %0d rollbacks of pending pushes, %0d drain pops past empty, %0d errors",
			n_rollbacks, n_empty_pops, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/crrq_pkg.sv
design/crrq_ctrl.sv
design/crrq_dp.sv
design/commit_rollback_ring_queue_top.sv
tb/sv/testbench.sv
